// ===== hw/rtl/rvr_pkg.sv =====
package rvr_pkg;

  // Fixed field widths
  localparam int VOLUME_W = 32;
  localparam int RATIO_W  = 32;
  localparam int STATUS_W = 2;
  localparam int PERIOD_W = 9;
  localparam int FRAC_W   = 16;

  // Parameter defaults
  localparam int MAX_PERIOD_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 32;

  // Reset value of the period register
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 9'd20;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZZ  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NZ  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // input transfer: latch sample, product and slot, read old entry
    logic warm_upd;  // warm-up: store sample, grow the sum
    logic commit;    // replace oldest entry, classify, start division if needed
    logic out_load;  // move the result into the output register
  } rvr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic warm;      // window not yet full
    logic direct;    // result known without division
    logic div_done;  // divider has finished
  } rvr_stat_t;

endpackage

// ===== hw/rtl/relative_volume_ratio_unit.sv =====
// Relative volume ratio. Each volume sample is divided by the mean of the
// PERIOD samples before it and the ratio comes out as unsigned Q16.16,
// rounded half up, in m_axis_tdata, with a status code in m_axis_tuser
// (0 ok, 1 saturated to all ones, 2 zero sample over zero baseline giving
// zero, 3 nonzero sample over zero baseline giving all ones). The first
// PERIOD samples after reset or after a period write only fill the window
// and give no result; writing the period restarts the window and must be
// done while the block is idle. Period 0 acts as 1, periods above
// MAX_PERIOD act as MAX_PERIOD. Only the low SAMPLE_BITS bits of a sample
// are used. A warm-up sample is loaded and then stored; a sample that
// gives a result is loaded, committed and, when it needs division, passed
// through the 33-step bit-serial divider. The result waits in an output
// register, so the next sample is taken while it is still pending.
module relative_volume_ratio_unit #(
  parameter int MAX_PERIOD  = rvr_pkg::MAX_PERIOD_DEF,
  parameter int SAMPLE_BITS = rvr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rvr_pkg::VOLUME_W-1:0]  s_axis_tdata,   // [31:0] volume
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rvr_pkg::RATIO_W-1:0]   m_axis_tdata,   // [31:0] ratio
  output logic [rvr_pkg::STATUS_W-1:0]  m_axis_tuser,   // [1:0] status
  input  logic                          cfg_we_i,
  input  logic [rvr_pkg::PERIOD_W-1:0]  cfg_wdata_i
);

  rvr_pkg::rvr_cmd_t  cmd;
  rvr_pkg::rvr_stat_t stat;

  rvr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rvr_dp #(
    .MAX_PERIOD  (MAX_PERIOD),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .volume_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .ratio_o     (m_axis_tdata),
    .status_o    (m_axis_tuser)
  );

  // At most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.warm_upd, cmd.commit, cmd.out_load}))
    else $error("controller issued more than one command");

  // A pending result is never overwritten
  a_out_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output register loaded while result pending");

  // Input closes after a transfer until the item is processed
  a_in_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !s_axis_tready)
    else $error("input still open after a transfer");

  // Division ends only while an item is in flight
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_done |-> !s_axis_tready)
    else $error("divider finished while controller idle");

endmodule

// ===== hw/rtl/rvr_div.sv =====
// Restoring divider: quotient of num * 2^17 / den, 33 bits, one bit a cycle.
// Caller guarantees num < den * 2^16, so the quotient fits in 33 bits.
module rvr_div #(
  parameter int NUM_W = 41,
  parameter int SUM_W = 40
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [NUM_W-1:0]           num_i,
  input  logic [SUM_W-1:0]           den_i,
  output logic                       done_o,
  output logic [rvr_pkg::RATIO_W-1:0] ratio_o,
  output logic                       ovf_o
);

  localparam int QW    = rvr_pkg::RATIO_W + 1;
  localparam int TPAD  = QW - rvr_pkg::FRAC_W;
  localparam int CNT_W = $clog2(QW + 1);

  logic [SUM_W-1:0] rem_q, rem_d, den_q;
  logic [QW-1:0]    tail_q, quo_q, rnd;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [SUM_W:0]   rem_sh, diff;
  logic             fits;

  // One restoring step
  always_comb begin
    rem_sh = {rem_q, tail_q[QW-1]};
    diff   = rem_sh - {1'b0, den_q};
    fits   = (rem_sh >= {1'b0, den_q});
    rem_d  = fits ? diff[SUM_W-1:0] : rem_sh[SUM_W-1:0];
  end

  // Control: busy flag, step counter, done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= SUM_W'(num_i[NUM_W-1:rvr_pkg::FRAC_W]);
      tail_q <= {num_i[rvr_pkg::FRAC_W-1:0], {TPAD{1'b0}}};
      quo_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      tail_q <= {tail_q[QW-2:0], 1'b0};
      quo_q  <= {quo_q[QW-2:0], fits};
    end
  end

  // Round half up on the extra bit; carry out means overflow
  assign rnd     = {1'b0, quo_q[QW-1:1]} + {{(QW-1){1'b0}}, quo_q[0]};
  assign ovf_o   = rnd[QW-1];
  assign ratio_o = rnd[QW-2:0];
  assign done_o  = done_q;

endmodule

// ===== hw/rtl/rvr_dp.sv =====
// Datapath: period register, window memory, running sum, product, divider,
// result and output registers.
module rvr_dp #(
  parameter int MAX_PERIOD  = rvr_pkg::MAX_PERIOD_DEF,
  parameter int SAMPLE_BITS = rvr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rvr_pkg::PERIOD_W-1:0]  cfg_wdata_i,
  input  logic [rvr_pkg::VOLUME_W-1:0]  volume_i,
  input  rvr_pkg::rvr_cmd_t             cmd_i,
  output rvr_pkg::rvr_stat_t            stat_o,
  output logic [rvr_pkg::RATIO_W-1:0]   ratio_o,
  output logic [rvr_pkg::STATUS_W-1:0]  status_o
);

  localparam int SW    = (SAMPLE_BITS < rvr_pkg::VOLUME_W) ? SAMPLE_BITS : rvr_pkg::VOLUME_W;
  localparam int PW    = rvr_pkg::PERIOD_W;
  localparam int AW    = $clog2(MAX_PERIOD);
  localparam int SUM_W = SW + AW;
  localparam int NUM_W = SW + PW;
  localparam int CMP_W = SUM_W + rvr_pkg::FRAC_W;

  logic [PW-1:0]    period_q, p_eff, fill_q;
  logic [AW-1:0]    wp_q, wp_eff, slot_q, slot_nxt;
  logic [AW:0]      slot_inc;
  logic [SUM_W-1:0] sum_q;
  logic [SW-1:0]    vol, v_q, rd_q;
  logic [NUM_W-1:0] num_q;
  logic             zero_sum, pre_ovf, store_we;
  logic             div_start, div_done, div_ovf;
  logic [rvr_pkg::RATIO_W-1:0]  div_ratio, res_ratio_q, out_ratio_q;
  logic [rvr_pkg::STATUS_W-1:0] res_status_q, out_status_q;

  logic [SW-1:0] store_mem [MAX_PERIOD];

  // Effective period: zero counts as one, clipped to the store depth
  always_comb begin
    if (period_q == '0) begin
      p_eff = PW'(1);
    end else if (32'(period_q) > 32'(MAX_PERIOD)) begin
      p_eff = PW'(MAX_PERIOD);
    end else begin
      p_eff = period_q;
    end
  end

  // Pointer wrap after a shorter period
  assign wp_eff   = (32'(wp_q) >= 32'(p_eff)) ? '0 : wp_q;
  assign slot_inc = {1'b0, slot_q} + (AW+1)'(1);
  assign slot_nxt = (32'(slot_inc) >= 32'(p_eff)) ? '0 : slot_inc[AW-1:0];

  assign vol = volume_i[SW-1:0];

  // Classification of the prior window
  assign zero_sum = (sum_q == '0);
  assign pre_ovf  = (CMP_W'(num_q) >= {sum_q, {rvr_pkg::FRAC_W{1'b0}}});

  assign stat_o.warm     = (fill_q < p_eff);
  assign stat_o.direct   = zero_sum || pre_ovf;
  assign stat_o.div_done = div_done;

  assign store_we  = cmd_i.warm_upd || cmd_i.commit;
  assign div_start = cmd_i.commit && !zero_sum && !pre_ovf;

  // Window store: one write and one registered read
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[slot_q] <= v_q;
    end
    if (cmd_i.load) begin
      rd_q <= store_mem[wp_eff];
    end
  end

  // Control state: period, fill count, pointer, running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= rvr_pkg::PERIOD_RST;
      fill_q   <= '0;
      wp_q     <= '0;
      sum_q    <= '0;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
      fill_q   <= '0;
      wp_q     <= '0;
      sum_q    <= '0;
    end else if (cmd_i.warm_upd) begin
      fill_q <= fill_q + PW'(1);
      wp_q   <= slot_nxt;
      sum_q  <= sum_q + SUM_W'(v_q);
    end else if (cmd_i.commit) begin
      wp_q  <= slot_nxt;
      sum_q <= sum_q - SUM_W'(rd_q) + SUM_W'(v_q);
    end
  end

  // Sample, product and slot captured on the input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q    <= vol;
      num_q  <= NUM_W'(vol) * NUM_W'(p_eff);
      slot_q <= wp_eff;
    end
  end

  rvr_div #(
    .NUM_W (NUM_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (sum_q),
    .done_o  (div_done),
    .ratio_o (div_ratio),
    .ovf_o   (div_ovf)
  );

  // Result register: direct cases at commit, quotient when the divider ends
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && zero_sum) begin
      if (v_q == '0) begin
        res_ratio_q  <= '0;
        res_status_q <= rvr_pkg::ST_ZZ;
      end else begin
        res_ratio_q  <= '1;
        res_status_q <= rvr_pkg::ST_NZ;
      end
    end else if (cmd_i.commit && pre_ovf) begin
      res_ratio_q  <= '1;
      res_status_q <= rvr_pkg::ST_SAT;
    end else if (div_done) begin
      res_ratio_q  <= div_ovf ? '1 : div_ratio;
      res_status_q <= div_ovf ? rvr_pkg::ST_SAT : rvr_pkg::ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ratio_q  <= res_ratio_q;
      out_status_q <= res_status_q;
    end
  end

  assign ratio_o  = out_ratio_q;
  assign status_o = out_status_q;

endmodule

// ===== hw/rtl/rvr_ctrl.sv =====
// Controller: sequences one item through read, update, division and output.
module rvr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  rvr_pkg::rvr_stat_t stat_i,
  output rvr_pkg::rvr_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_READ;
        end
      end
      S_READ: begin
        if (stat_i.warm) begin
          cmd_o.warm_upd = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = stat_i.direct ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
